[hdl/assert_macros.svh]
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition in one cycle implies another condition in the next one.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/bile_pkg.sv]
// Types, request kinds and status codes for the bounded integer list engine.
package bile_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int DATA_W           = 32;

   localparam logic [2:0] KIND_APPEND     = 3'd0;
   localparam logic [2:0] KIND_REMOVE_AT  = 3'd1;
   localparam logic [2:0] KIND_REMOVE_VAL = 3'd2;
   localparam logic [2:0] KIND_READ       = 3'd3;
   localparam logic [2:0] KIND_CONTAINS   = 3'd4;
   localparam logic [2:0] KIND_CLEAR      = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_POS   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]               kind;
      logic [5:0]               position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [5:0]               found_index;
      logic [1:0]               status;
      logic [6:0]               count;
      logic                     is_empty;
   } rsp_type;

   // Finished result offered by the sequencer to the output stage.
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } res_type;

endpackage

[hdl/bounded_int_list_engine.sv]
// Append, clear, unused kinds and refused requests go from the idle state straight to done.
// Read and remove-at first read the entry; remove-at then shifts the later entries down.
// Contains scans from the head until a match or the end of the list; remove-by-value scans
// likewise, then shifts later entries down. Throughput: one request at a time, since the next
// is taken only once the result has moved to the output register; walks use one access a cycle.
// Synchronous active-high reset empties the list; entry contents are not cleared.
`include "assert_macros.svh"

module bounded_int_list_engine #(
   parameter int CAPACITY = bile_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bile_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bile_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);

   // Sequencer to output stage.
   bile_pkg::res_type res;
   logic              slot_free;

   // Entry store ports.
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [bile_pkg::DATA_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [bile_pkg::DATA_W-1:0] rd_data;

   // Output register: holds a finished result while the sequencer takes the next request.
   logic              rsp_valid_ff, rsp_valid_in;
   bile_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   bile_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .slot_free (slot_free),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   bile_ram #(
      .WIDTH (bile_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The slot frees up when empty or when its request leaves this cycle.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid && slot_free) begin
         // Load the finished request.
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.rsp;
      end else if (rsp_ready) begin
         // Drop the delivered request.
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A taken request makes the sequencer busy, so requests are never accepted back to back.
   `ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready right after accept")
   // A refused or missed request never carries a value.
   `ASSERT_ALWAYS(a_data_zero_on_error, !rsp_valid || rsp_data.status == bile_pkg::ST_OK || rsp_data.data == '0, "data set on error status")
   // A full refusal only happens at capacity.
   `ASSERT_ALWAYS(a_full_at_capacity, !res.valid || res.rsp.status != bile_pkg::ST_FULL || res.rsp.count == 7'(CAPACITY), "full status below capacity")
   // A result waiting on the sequencer is never lost while the slot is taken.
   `ASSERT_NEXT(a_result_held, res.valid && !slot_free, res.valid, "result dropped while output busy")

endmodule

[hdl/bile_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
module bile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bile_seq.sv]
// Request sequencer: decodes a request and walks the entry store one access a cycle.
module bile_seq #(
   parameter int CAPACITY = bile_pkg::CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bile_pkg::req_type            req_data,
   input  logic                         slot_free,
   output bile_pkg::res_type            res,
   output logic                         wr_en,
   output logic [$clog2(CAPACITY)-1:0]  wr_addr,
   output logic [bile_pkg::DATA_W-1:0]  wr_data,
   output logic                         rd_en,
   output logic [$clog2(CAPACITY)-1:0]  rd_addr,
   input  logic [bile_pkg::DATA_W-1:0]  rd_data
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;
   localparam int WW   = (CW > 7) ? CW : 7;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RDWAIT = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]                  state_ff,  state_in;
   logic [2:0]                  kind_ff,   kind_in;
   logic [bile_pkg::DATA_W-1:0] val_ff,    val_in;
   logic [CW-1:0]               used_ff,   used_in;
   logic [CW-1:0]               idx_ff,    idx_in;
   logic [AW-1:0]               wa_ff,     wa_in;
   logic                        pend_ff,   pend_in;
   logic [bile_pkg::DATA_W-1:0] data_ff,   data_in;
   logic [5:0]                  fidx_ff,   fidx_in;
   logic [1:0]                  status_ff, status_in;

   logic [CMPW-1:0] pos_ext;
   logic            pos_bad;
   logic            idx_lt_used;
   logic            hit;
   logic [CW-1:0]   idx_dec;
   logic [WW-1:0]   where_wide;
   logic [WW-1:0]   cnt_wide;

   assign pos_ext     = CMPW'(req_data.position);
   assign pos_bad     = pos_ext >= CMPW'(used_ff);
   assign idx_lt_used = idx_ff < used_ff;
   // Shared comparator: the only value compare in the block.
   assign hit         = pend_ff && (rd_data == val_ff);
   assign idx_dec     = idx_ff - CW'(1);
   assign where_wide  = WW'(wa_ff);
   assign cnt_wide    = WW'(used_ff);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      val_in    = val_ff;
      used_in   = used_ff;
      idx_in    = idx_ff;
      wa_in     = wa_ff;
      pend_in   = pend_ff;
      data_in   = data_ff;
      fidx_in   = fidx_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = wa_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_data.kind;
               val_in    = req_data.value;
               data_in   = '0;
               fidx_in   = '0;
               status_in = bile_pkg::ST_OK;
               unique case (req_data.kind) inside
                  bile_pkg::KIND_APPEND: begin
                     if (used_ff >= CW'(CAPACITY)) begin
                        status_in = bile_pkg::ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = used_ff[AW-1:0];
                        wr_data = req_data.value;
                        used_in = used_ff + CW'(1);
                     end
                     state_in = S_DONE;
                  end
                  bile_pkg::KIND_REMOVE_AT, bile_pkg::KIND_READ: begin
                     if (pos_bad) begin
                        status_in = bile_pkg::ST_BAD_POS;
                        state_in  = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_ext[AW-1:0];
                        wa_in    = pos_ext[AW-1:0];
                        state_in = S_RDWAIT;
                     end
                  end
                  bile_pkg::KIND_REMOVE_VAL, bile_pkg::KIND_CONTAINS: begin
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_SCAN;
                  end
                  bile_pkg::KIND_CLEAR: begin
                     used_in  = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            data_in = rd_data;
            if (kind_ff == bile_pkg::KIND_REMOVE_AT) begin
               idx_in   = CW'(wa_ff) + CW'(1);
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (hit) begin
               pend_in = 1'b0;
               if (kind_ff == bile_pkg::KIND_REMOVE_VAL) begin
                  data_in  = rd_data;
                  fidx_in  = where_wide[5:0];
                  idx_in   = CW'(wa_ff) + CW'(1);
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (idx_lt_used) begin
               rd_en   = 1'b1;
               wa_in   = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               status_in = bile_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_SHIFT: begin
            // Move the entry read last cycle down by one place.
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (idx_lt_used) begin
               rd_en   = 1'b1;
               wa_in   = idx_dec[AW-1:0];
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               used_in  = used_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      wa_ff     <= wa_in;
      data_ff   <= data_in;
      fidx_ff   <= fidx_in;
      status_ff <= status_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign res.valid           = (state_ff == S_DONE);
   assign res.rsp.data        = data_ff;
   assign res.rsp.found_index = fidx_ff;
   assign res.rsp.status      = status_ff;
   assign res.rsp.count       = cnt_wide[6:0];
   assign res.rsp.is_empty    = (used_ff == '0);

endmodule

[test/tb.sv]
// Self-checking testbench for the bounded integer list engine: directed table, then random mixes.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH    = bile_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS  = 830;
   localparam int MAX_IDLE      = 17;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 200;

   // Kinds the block leaves unused; they must change nothing and report ok.
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   localparam logic [bile_pkg::DATA_W-1:0] MIN_VALUE = 32'h8000_0000;
   localparam logic [bile_pkg::DATA_W-1:0] MAX_VALUE = 32'h7FFF_FFFF;
   localparam logic [bile_pkg::DATA_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

   typedef enum int {MIX_GENERAL, MIX_FILL, MIX_DRAIN, MIX_NOISE} mix_mode_type;

   // One line of the directed table: the request and, where typed in, its result.
   typedef struct {
      bile_pkg::req_type req;
      bit                typed;
      bile_pkg::rsp_type want;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   bile_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   bile_pkg::rsp_type rsp_data;

   // Shadow copy of the list: contents and entry count after every accepted request.
   logic signed [bile_pkg::DATA_W-1:0] list_mem [LIST_DEPTH];
   int list_len = 0;

   bile_pkg::rsp_type expected_q [$];
   plan_row_type      plan [$];

   int mismatch_count = 0;
   int n_requests     = 0;
   int n_live         = 0;
   int n_responses    = 0;
   int n_full         = 0;
   int n_bad_pos      = 0;
   int n_miss         = 0;
   int kind_hits [8]  = '{default: 0};

   bit hold_off_pending  = 1'b0;
   bit sender_eager      = 1'b0;
   bit pause_before_next = 1'b0;

   bounded_int_list_engine #(.CAPACITY(LIST_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Return the index of the first entry equal to v, or -1 on a miss.
   function automatic int find_entry(logic signed [bile_pkg::DATA_W-1:0] v);
      for (int i = 0; i < list_len; i++)
         if (list_mem[i] == v) return i;
      return -1;
   endfunction

   // Drop the entry at idx and shift later entries down by one.
   function automatic void close_gap(int idx);
      for (int i = idx; i + 1 < list_len; i++)
         list_mem[i] = list_mem[i + 1];
      list_len--;
   endfunction

   // Apply one request to the shadow list and return the result the block must give.
   function automatic bile_pkg::rsp_type apply_list_request(bile_pkg::req_type r);
      bile_pkg::rsp_type res;
      int                hit;
      res        = '0;
      res.status = bile_pkg::ST_OK;
      case (r.kind)
         bile_pkg::KIND_APPEND: begin
            if (list_len >= LIST_DEPTH) begin
               res.status = bile_pkg::ST_FULL;
            end else begin
               list_mem[list_len] = r.value;
               list_len++;
            end
         end
         bile_pkg::KIND_REMOVE_AT: begin
            if (int'(r.position) >= list_len) begin
               res.status = bile_pkg::ST_BAD_POS;
            end else begin
               res.data = list_mem[r.position];
               close_gap(int'(r.position));
            end
         end
         bile_pkg::KIND_REMOVE_VAL: begin
            hit = find_entry(r.value);
            if (hit < 0) begin
               res.status = bile_pkg::ST_NOT_FOUND;
            end else begin
               res.data        = list_mem[hit];
               res.found_index = hit[5:0];
               close_gap(hit);
            end
         end
         bile_pkg::KIND_READ: begin
            if (int'(r.position) >= list_len) begin
               res.status = bile_pkg::ST_BAD_POS;
            end else begin
               res.data = list_mem[r.position];
            end
         end
         bile_pkg::KIND_CONTAINS: begin
            if (find_entry(r.value) < 0) res.status = bile_pkg::ST_NOT_FOUND;
         end
         bile_pkg::KIND_CLEAR: begin
            list_len = 0;
         end
         default: ;
      endcase
      res.count    = list_len[6:0];
      res.is_empty = (list_len == 0);
      return res;
   endfunction

   function automatic bile_pkg::req_type make_req(logic [2:0] kind, logic [5:0] pos,
                                                  logic [bile_pkg::DATA_W-1:0] value);
      bile_pkg::req_type r;
      r.kind     = kind;
      r.position = pos;
      r.value    = value;
      return r;
   endfunction

   // Add a table row; the result fields only matter when typed is set.
   function automatic void plan_row(logic [2:0] kind, logic [5:0] pos,
                                    logic [bile_pkg::DATA_W-1:0] value, bit typed,
                                    logic [bile_pkg::DATA_W-1:0] data, logic [5:0] fidx,
                                    logic [1:0] st, logic [6:0] cnt);
      plan_row_type row;
      row.req              = make_req(kind, pos, value);
      row.typed            = typed;
      row.want.data        = data;
      row.want.found_index = fidx;
      row.want.status      = st;
      row.want.count       = cnt;
      row.want.is_empty    = (cnt == 0);
      plan.push_back(row);
   endfunction

   // Favor stored values so that searches hit, with corner values and noise mixed in.
   function automatic logic [bile_pkg::DATA_W-1:0] pick_value(int existing_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (list_len > 0 && roll < existing_pct)
         return list_mem[$urandom_range(0, list_len - 1)];
      if (roll < existing_pct + 20) begin
         case ($urandom_range(0, 4))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return MIN_VALUE;
            3:       return MAX_VALUE;
            default: return 32'd1;
         endcase
      end
      return $urandom;
   endfunction

   // Mostly a valid index; sometimes any value the field can carry.
   function automatic logic [5:0] pick_position();
      if (list_len > 0 && $urandom_range(0, 99) < 75)
         return 6'($urandom_range(0, list_len - 1));
      return 6'($urandom);
   endfunction

   function automatic bile_pkg::req_type random_request(mix_mode_type mode);
      int         roll;
      logic [2:0] kind;
      roll = $urandom_range(0, 99);
      case (mode)
         MIX_FILL:  kind = (roll < 85) ? bile_pkg::KIND_APPEND
                                       : ((roll < 93) ? bile_pkg::KIND_READ
                                                      : bile_pkg::KIND_CONTAINS);
         MIX_DRAIN: kind = (roll < 55) ? bile_pkg::KIND_REMOVE_AT
                                       : ((roll < 95) ? bile_pkg::KIND_REMOVE_VAL
                                                      : bile_pkg::KIND_READ);
         MIX_NOISE: kind = 3'($urandom_range(0, 7));
         default: begin
            if (roll < 30)      kind = bile_pkg::KIND_APPEND;
            else if (roll < 45) kind = bile_pkg::KIND_REMOVE_AT;
            else if (roll < 60) kind = bile_pkg::KIND_REMOVE_VAL;
            else if (roll < 78) kind = bile_pkg::KIND_READ;
            else if (roll < 93) kind = bile_pkg::KIND_CONTAINS;
            else if (roll < 95) kind = bile_pkg::KIND_CLEAR;
            else if (roll < 98) kind = KIND_SPARE_6;
            else                kind = KIND_SPARE_7;
         end
      endcase
      return make_req(kind, pick_position(), pick_value((mode == MIX_DRAIN) ? 85 : 45));
   endfunction

   // Offer one request, hold it until accepted, then log what the block owes us.
   task automatic offer_request(bile_pkg::req_type r, bit typed, bile_pkg::rsp_type want);
      int                gap;
      bile_pkg::rsp_type predicted;
      gap = sender_eager ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0 || pause_before_next) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if (pause_before_next) begin
            // Let the block run dry before the next request goes in.
            @(posedge clock);
            wait (expected_q.size() == 0);
            pause_before_next = 1'b0;
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_list_request(r);
      expected_q.push_back(typed ? want : predicted);
      n_requests++;
      kind_hits[r.kind]++;
      if (r.kind != KIND_SPARE_6 && r.kind != KIND_SPARE_7) n_live++;
      if (predicted.status == bile_pkg::ST_FULL)      n_full++;
      if (predicted.status == bile_pkg::ST_BAD_POS)   n_bad_pos++;
      if (predicted.status == bile_pkg::ST_NOT_FOUND) n_miss++;
   endtask

   // Compare one accepted response with the oldest outstanding expectation.
   task automatic check_response(bile_pkg::rsp_type got);
      bile_pkg::rsp_type want;
      n_responses++;
      if (expected_q.size() == 0) begin
         $error("response with no request outstanding: count %0d status %0d",
                got.count, got.status);
         mismatch_count++;
      end else begin
         want = expected_q.pop_front();
         if (got.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, got.data);
            mismatch_count++;
         end
         if (got.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
            mismatch_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            mismatch_count++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            mismatch_count++;
         end
      end
   endtask

   // Response side: random stalls, idle-free stretches, and long hold-offs on request.
   initial begin
      int stall;
      int eager_left;
      eager_left = 0;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            // Hold off long enough that the block backs up and refuses new requests.
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (eager_left > 0) begin
               stall = 0;
               eager_left--;
            end else if ($urandom_range(0, 24) == 0) begin
               stall      = 0;
               eager_left = $urandom_range(10, 40);
            end else begin
               stall = $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_response(rsp_data);
      end
   end

   // Request side: reset, directed table, random episodes, then drain and report.
   initial begin
      mix_mode_type mode;
      int           episode;
      int           roll;
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;

      // Empty list: bad-position and not-found refusals, clear and unused kinds.
      plan_row(bile_pkg::KIND_READ,       6'd0,  '0,        1, '0, 6'd0,
               bile_pkg::ST_BAD_POS,   7'd0);
      plan_row(bile_pkg::KIND_REMOVE_AT,  6'd63, '0,        1, '0, 6'd0,
               bile_pkg::ST_BAD_POS,   7'd0);
      plan_row(bile_pkg::KIND_REMOVE_VAL, 6'd0,  '0,        1, '0, 6'd0,
               bile_pkg::ST_NOT_FOUND, 7'd0);
      plan_row(bile_pkg::KIND_CONTAINS,   6'd0,  MIN_VALUE, 1, '0, 6'd0,
               bile_pkg::ST_NOT_FOUND, 7'd0);
      plan_row(bile_pkg::KIND_CLEAR,      6'd0,  '0,        1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd0);
      plan_row(KIND_SPARE_6,              6'd63, ALL_ONES,  1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd0);
      plan_row(KIND_SPARE_7,              6'd0,  '0,        1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd0);
      // Extreme values in, then read them back at both ends and just past the end.
      plan_row(bile_pkg::KIND_APPEND,     6'd63, MIN_VALUE, 1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd1);
      plan_row(bile_pkg::KIND_APPEND,     6'd0,  MAX_VALUE, 1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd2);
      plan_row(bile_pkg::KIND_APPEND,     6'd0,  ALL_ONES,  1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd3);
      plan_row(bile_pkg::KIND_APPEND,     6'd0,  '0,        1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd4);
      plan_row(bile_pkg::KIND_READ,       6'd0,  '0,        1, MIN_VALUE, 6'd0,
               bile_pkg::ST_OK,        7'd4);
      plan_row(bile_pkg::KIND_READ,       6'd3,  '0,        1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd4);
      plan_row(bile_pkg::KIND_READ,       6'd4,  '0,        1, '0, 6'd0,
               bile_pkg::ST_BAD_POS,   7'd4);
      plan_row(bile_pkg::KIND_CONTAINS,   6'd0,  ALL_ONES,  1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd4);
      plan_row(bile_pkg::KIND_CONTAINS,   6'd0,  32'd5,     1, '0, 6'd0,
               bile_pkg::ST_NOT_FOUND, 7'd4);
      // Removals: match in the middle, head of list, and an index far out of range.
      plan_row(bile_pkg::KIND_REMOVE_VAL, 6'd0,  MAX_VALUE, 1, MAX_VALUE, 6'd1,
               bile_pkg::ST_OK,        7'd3);
      plan_row(bile_pkg::KIND_REMOVE_AT,  6'd0,  '0,        1, MIN_VALUE, 6'd0,
               bile_pkg::ST_OK,        7'd2);
      plan_row(bile_pkg::KIND_REMOVE_AT,  6'd63, '0,        1, '0, 6'd0,
               bile_pkg::ST_BAD_POS,   7'd2);
      // Duplicate value: remove-by-value must take the first match.
      plan_row(bile_pkg::KIND_APPEND,     6'd21, ALL_ONES,  0, '0, 6'd0,
               bile_pkg::ST_OK,        7'd0);
      plan_row(bile_pkg::KIND_READ,       6'd2,  '0,        0, '0, 6'd0,
               bile_pkg::ST_OK,        7'd0);
      plan_row(bile_pkg::KIND_REMOVE_VAL, 6'd0,  ALL_ONES,  1, ALL_ONES, 6'd0,
               bile_pkg::ST_OK,        7'd2);
      plan_row(bile_pkg::KIND_REMOVE_AT,  6'd1,  '0,        1, ALL_ONES, 6'd0,
               bile_pkg::ST_OK,        7'd1);
      plan_row(bile_pkg::KIND_CLEAR,      6'd0,  '0,        1, '0, 6'd0,
               bile_pkg::ST_OK,        7'd0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) offer_request(plan[i].req, plan[i].typed, plan[i].want);

      // Random episodes: fill to capacity, drain to empty, general mixes and noise.
      episode = 0;
      while (n_live < plan.size() + RANDOM_ITEMS) begin
         sender_eager = ($urandom_range(0, 3) == 0);
         if (episode == 2 || episode == 11) hold_off_pending = 1'b1;
         if (episode % 5 == 4) pause_before_next = 1'b1;
         roll = $urandom_range(0, 99);
         if (episode == 0 || roll < 20) mode = MIX_FILL;
         else if (roll < 40)            mode = MIX_DRAIN;
         else if (roll < 50)            mode = MIX_NOISE;
         else                           mode = MIX_GENERAL;
         case (mode)
            MIX_FILL: begin
               while (list_len < LIST_DEPTH) offer_request(random_request(MIX_FILL), 1'b0, '0);
               // Push past capacity to get the full refusal.
               repeat ($urandom_range(1, 3))
                  offer_request(make_req(bile_pkg::KIND_APPEND, pick_position(), $urandom),
                                1'b0, '0);
            end
            MIX_DRAIN: begin
               while (list_len > 0) offer_request(random_request(MIX_DRAIN), 1'b0, '0);
               repeat (2) offer_request(random_request(MIX_DRAIN), 1'b0, '0);
            end
            MIX_NOISE: begin
               repeat ($urandom_range(3, 8)) offer_request(random_request(MIX_NOISE), 1'b0, '0);
            end
            default: begin
               repeat ($urandom_range(15, 40))
                  offer_request(random_request(MIX_GENERAL), 1'b0, '0);
            end
         endcase
         episode++;
      end

      // Drop valid, wait for the last response, then watch for strays.
      req_valid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Coverage: %0d requests (%0d append, %0d remove-at, %0d remove-by-value, %0d read,",
               n_requests, kind_hits[bile_pkg::KIND_APPEND], kind_hits[bile_pkg::KIND_REMOVE_AT],
               kind_hits[bile_pkg::KIND_REMOVE_VAL], kind_hits[bile_pkg::KIND_READ]);
      $display("  %0d contains, %0d clear, %0d unused kind); %0d full, %0d bad position, %0d miss",
               kind_hits[bile_pkg::KIND_CONTAINS], kind_hits[bile_pkg::KIND_CLEAR],
               kind_hits[KIND_SPARE_6] + kind_hits[KIND_SPARE_7], n_full, n_bad_pos, n_miss);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/bile_pkg.sv
hdl/bile_ram.sv
hdl/bile_seq.sv
hdl/bounded_int_list_engine.sv
test/tb.sv
